// ===== rtl/core/lpne_pkg.sv =====
package lpne_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        logic [9:0]  high_count;
        logic [15:0] low_count;
        logic        is_latch;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [2:0]  wire_order;
        logic        four_bytes;
        logic [7:0]  brightness;
        logic [9:0]  one_high_samples;
        logic [9:0]  zero_high_samples;
        logic [9:0]  bit_samples;
        logic [15:0] reset_samples;
    } t_cfg;

    typedef struct packed {
        logic [3:0][7:0] wire_bytes;
        logic            four_bytes;
        logic            frame_end;
    } t_word;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIRE_ORDER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SAMPLES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_GAP   = 3'd6;

    localparam logic [2:0] ORD_RGB  = 3'd0;
    localparam logic [2:0] ORD_RBG  = 3'd1;
    localparam logic [2:0] ORD_GRB  = 3'd2;
    localparam logic [2:0] ORD_GBR  = 3'd3;
    localparam logic [2:0] ORD_BRG  = 3'd4;
    localparam logic [2:0] ORD_BGR  = 3'd5;
    localparam logic [2:0] ORD_RGBW = 3'd6;
    localparam logic [2:0] ORD_GRBW = 3'd7;

    localparam logic [15:0] ROUND_HALF = 16'd128;

    function automatic logic [7:0] scale_byte(input logic [7:0] x, input logic [7:0] gain);
        logic [15:0] prod;
        prod = {8'b0, x} * {8'b0, gain} + ROUND_HALF;
        return prod[15:8];
    endfunction

endpackage

// ===== rtl/core/lpne_front.sv =====
module lpne_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpne_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  lpne_pkg::t_pixel i_pixel,
    input  logic            i_q_full,
    output logic            o_push,
    output lpne_pkg::t_word o_word
);
    import lpne_pkg::*;

    logic       r_vld;
    t_word      r_word;
    logic [7:0] w0, w1, w2;
    logic       accept;

    always_comb begin
        case (i_cfg.wire_order)
            ORD_RBG: begin
                w0 = i_pixel.red;   w1 = i_pixel.blue;  w2 = i_pixel.green;
            end
            ORD_GRB, ORD_GRBW: begin
                w0 = i_pixel.green; w1 = i_pixel.red;   w2 = i_pixel.blue;
            end
            ORD_GBR: begin
                w0 = i_pixel.green; w1 = i_pixel.blue;  w2 = i_pixel.red;
            end
            ORD_BRG: begin
                w0 = i_pixel.blue;  w1 = i_pixel.red;   w2 = i_pixel.green;
            end
            ORD_BGR: begin
                w0 = i_pixel.blue;  w1 = i_pixel.green; w2 = i_pixel.red;
            end
            ORD_RGB, ORD_RGBW: begin
                w0 = i_pixel.red;   w1 = i_pixel.green; w2 = i_pixel.blue;
            end
            default: begin
                w0 = i_pixel.red;   w1 = i_pixel.green; w2 = i_pixel.blue;
            end
        endcase
    end

    assign o_stall = r_vld && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld && !i_q_full;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.wire_bytes[0] <= scale_byte(w0, i_cfg.brightness);
            r_word.wire_bytes[1] <= scale_byte(w1, i_cfg.brightness);
            r_word.wire_bytes[2] <= scale_byte(w2, i_cfg.brightness);
            r_word.wire_bytes[3] <= scale_byte(i_pixel.white, i_cfg.brightness);
            r_word.four_bytes    <= i_cfg.four_bytes;
            r_word.frame_end     <= i_pixel.frame_end;
        end
    end

endmodule

// ===== rtl/core/lpne_queue.sv =====
module lpne_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpne_pkg::t_word i_word,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_vld,
    output lpne_pkg::t_word o_word
);
    import lpne_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_word         r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_word  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/lpne_back.sv =====
module lpne_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpne_pkg::t_cfg    i_cfg,
    input  logic              i_q_vld,
    input  lpne_pkg::t_word   i_word,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output lpne_pkg::t_result o_result
);
    import lpne_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DATA,
        S_LATCH
    } t_state;

    t_state      r_state;
    t_word       r_word;
    logic [1:0]  r_byte;
    logic [2:0]  r_bit;
    logic        r_out_vld;
    t_result     r_out;

    logic        can_load;
    logic        cur_bit;
    logic        final_bit;
    logic [9:0]  hi;
    logic [15:0] lo;

    assign can_load  = !r_out_vld || !i_stall;
    assign cur_bit   = r_word.wire_bytes[r_byte][r_bit];
    assign final_bit = (r_bit == 3'd0) && (r_byte == (r_word.four_bytes ? 2'd3 : 2'd2));
    assign hi        = cur_bit ? i_cfg.one_high_samples : i_cfg.zero_high_samples;
    assign lo        = (i_cfg.bit_samples > hi) ? {6'b0, i_cfg.bit_samples - hi} : '0;

    assign o_pop = i_q_vld && ((r_state == S_IDLE) ||
                   (can_load && r_state == S_DATA && final_bit && !r_word.frame_end) ||
                   (can_load && r_state == S_LATCH));

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (can_load) begin
                        r_out_vld <= 1'b1;
                        if (final_bit) begin
                            if (r_word.frame_end) begin
                                r_state <= S_LATCH;
                            end else if (!o_pop) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_LATCH: begin
                    if (can_load) begin
                        r_out_vld <= 1'b1;
                        r_state   <= o_pop ? S_DATA : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_word;
            r_byte <= 2'd0;
            r_bit  <= 3'd7;
        end else if (r_state == S_DATA && can_load) begin
            if (r_bit == 3'd0) begin
                r_byte <= r_byte + 2'd1;
            end
            r_bit <= r_bit - 3'd1;
        end
        if (r_state == S_DATA && can_load) begin
            r_out.high_count <= hi;
            r_out.low_count  <= lo;
            r_out.is_latch   <= 1'b0;
            r_out.last       <= final_bit && !r_word.frame_end;
        end else if (r_state == S_LATCH && can_load) begin
            r_out.high_count <= '0;
            r_out.low_count  <= i_cfg.reset_samples;
            r_out.is_latch   <= 1'b1;
            r_out.last       <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/led_pixel_nrz_encoder_top.sv =====
// Channel   | Handshake          | Beat
// ----------+--------------------+------------------------------------------
// pixel in  | i_valid / o_stall  | i_pixel: red, green, blue, white, frame_end
// result out| o_valid / i_stall  | o_result: high_count, low_count, is_latch, last
// config    | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One result beat leaves per cycle while i_stall is low and pixels are queued; a pixel
// gives 24 beats (32 with four_bytes), plus the latch beat when frame_end is set. The bit
// serializer sets that rate. Pixels pass the front, queue, word and result registers in turn.
// Reset is synchronous, active low; it loads the register defaults and empties the queue.
// A stalled output holds its beat; the queue of QUEUE_DEPTH pixels absorbs input bursts.
module led_pixel_nrz_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  lpne_pkg::t_pixel                    i_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lpne_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [lpne_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lpne_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lpne_pkg::*;

    t_cfg  r_cfg;
    t_word front_word, q_word;
    logic  q_full, push, q_vld, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wire_order        <= ORD_GRB;
            r_cfg.four_bytes        <= 1'b0;
            r_cfg.brightness        <= 8'd255;
            r_cfg.one_high_samples  <= 10'd8;
            r_cfg.zero_high_samples <= 10'd4;
            r_cfg.bit_samples       <= 10'd12;
            r_cfg.reset_samples     <= 16'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIRE_ORDER:  r_cfg.wire_order        <= i_cfg_data[2:0];
                CFG_FOUR_BYTES:  r_cfg.four_bytes        <= i_cfg_data[0];
                CFG_BRIGHTNESS:  r_cfg.brightness        <= i_cfg_data[7:0];
                CFG_ONE_HIGH:    r_cfg.one_high_samples  <= i_cfg_data[9:0];
                CFG_ZERO_HIGH:   r_cfg.zero_high_samples <= i_cfg_data[9:0];
                CFG_BIT_SAMPLES: r_cfg.bit_samples       <= i_cfg_data[9:0];
                CFG_RESET_GAP:   r_cfg.reset_samples     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lpne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_pixel  (i_pixel),
        .i_q_full (q_full),
        .o_push   (push),
        .o_word   (front_word)
    );

    lpne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_word  (q_word)
    );

    lpne_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_vld  (q_vld),
        .i_word   (q_word),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

// ===== rtl/core/lpne_checker.sv =====
module lpne_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input lpne_pkg::t_result o_result
);
    import lpne_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled result beat changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

    a_latch_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.is_latch |-> o_result.last && (o_result.high_count == '0))
        else $error("latch beat malformed");

endmodule

bind led_pixel_nrz_encoder_top lpne_checker u_lpne_checker (.*);

// ===== bench/tb.sv =====
module tb;
    import lpne_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    class bit_timing_scoreboard;
        t_cfg    regs;
        t_result beats_due[$];
        int      n_bad;

        function new();
            regs.wire_order        = ORD_GRB;
            regs.four_bytes        = 1'b0;
            regs.brightness        = 8'd255;
            regs.one_high_samples  = 10'd8;
            regs.zero_high_samples = 10'd4;
            regs.bit_samples       = 10'd12;
            regs.reset_samples     = 16'd500;
            n_bad = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIRE_ORDER:  regs.wire_order        = data[2:0];
                CFG_FOUR_BYTES:  regs.four_bytes        = data[0];
                CFG_BRIGHTNESS:  regs.brightness        = data[7:0];
                CFG_ONE_HIGH:    regs.one_high_samples  = data[9:0];
                CFG_ZERO_HIGH:   regs.zero_high_samples = data[9:0];
                CFG_BIT_SAMPLES: regs.bit_samples       = data[9:0];
                CFG_RESET_GAP:   regs.reset_samples     = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        function logic [7:0] dim(logic [7:0] x);
            int unsigned p;
            p = x * regs.brightness + 128;
            return p[15:8];
        endfunction

        function void add_pixel(t_pixel px);
            logic [7:0] lane [4];
            logic [7:0] byt;
            logic [9:0] hi;
            t_result    r;
            int         nb;
            case (regs.wire_order)
                ORD_RBG: begin
                    lane[0] = px.red;   lane[1] = px.blue;  lane[2] = px.green;
                end
                ORD_GRB, ORD_GRBW: begin
                    lane[0] = px.green; lane[1] = px.red;   lane[2] = px.blue;
                end
                ORD_GBR: begin
                    lane[0] = px.green; lane[1] = px.blue;  lane[2] = px.red;
                end
                ORD_BRG: begin
                    lane[0] = px.blue;  lane[1] = px.red;   lane[2] = px.green;
                end
                ORD_BGR: begin
                    lane[0] = px.blue;  lane[1] = px.green; lane[2] = px.red;
                end
                default: begin
                    lane[0] = px.red;   lane[1] = px.green; lane[2] = px.blue;
                end
            endcase
            lane[3] = px.white;
            nb = regs.four_bytes ? 4 : 3;
            for (int i = 0; i < nb; i++) begin
                byt = dim(lane[i]);
                for (int b = 7; b >= 0; b--) begin
                    hi = byt[b] ? regs.one_high_samples : regs.zero_high_samples;
                    r.high_count = hi;
                    r.low_count  = (regs.bit_samples > hi) ? 16'(regs.bit_samples - hi) : 16'd0;
                    r.is_latch   = 1'b0;
                    r.last       = !px.frame_end && i == nb - 1 && b == 0;
                    beats_due.push_back(r);
                end
            end
            if (px.frame_end) begin
                r.high_count = 10'd0;
                r.low_count  = regs.reset_samples;
                r.is_latch   = 1'b1;
                r.last       = 1'b1;
                beats_due.push_back(r);
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (beats_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("unexpected beat: hi=%0d lo=%0d latch=%b last=%b",
                             got.high_count, got.low_count, got.is_latch, got.last);
                end
                return;
            end
            want = beats_due.pop_front();
            if (got.high_count !== want.high_count || got.low_count !== want.low_count ||
                got.is_latch !== want.is_latch || got.last !== want.last) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("beat mismatch: expected hi=%0d lo=%0d latch=%b last=%b",
                             want.high_count, want.low_count, want.is_latch, want.last);
                    $display("               got      hi=%0d lo=%0d latch=%b last=%b",
                             got.high_count, got.low_count, got.is_latch, got.last);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_pixel                i_pixel;
    logic                  o_valid;
    logic                  i_stall;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bit tx_quiet;
    bit rx_quiet;
    bit_timing_scoreboard sb;

    led_pixel_nrz_encoder_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(8 * 1_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic int idle_span();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 16);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px.red       = rand_byte();
        px.green     = rand_byte();
        px.blue      = rand_byte();
        px.white     = rand_byte();
        px.frame_end = ($urandom_range(0, 3) == 0);
        return px;
    endfunction

    function automatic logic [9:0] rand_high();
        case ($urandom_range(0, 3))
            0: return 10'd0;
            1: return 10'd1023;
            default: return 10'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic t_cfg rand_settings();
        t_cfg c;
        c.wire_order        = 3'($urandom_range(0, 7));
        c.four_bytes        = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: c.brightness = 8'd0;
            1: c.brightness = 8'd255;
            default: c.brightness = 8'($urandom_range(0, 255));
        endcase
        c.one_high_samples  = rand_high();
        c.zero_high_samples = rand_high();
        case ($urandom_range(0, 4))
            0: c.bit_samples = 10'd0;
            1: c.bit_samples = 10'd1;
            2: c.bit_samples = 10'd1023;
            default: c.bit_samples = 10'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 3))
            0: c.reset_samples = 16'd0;
            1: c.reset_samples = 16'hffff;
            default: c.reset_samples = 16'($urandom_range(0, 65535));
        endcase
        return c;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        settle();
        cfg_write(CFG_WIRE_ORDER,  16'(c.wire_order));
        cfg_write(CFG_FOUR_BYTES,  16'(c.four_bytes));
        cfg_write(CFG_BRIGHTNESS,  16'(c.brightness));
        cfg_write(CFG_ONE_HIGH,    16'(c.one_high_samples));
        cfg_write(CFG_ZERO_HIGH,   16'(c.zero_high_samples));
        cfg_write(CFG_BIT_SAMPLES, 16'(c.bit_samples));
        cfg_write(CFG_RESET_GAP,   c.reset_samples);
        cfg_write(CFG_IDX_SPARE,   16'($urandom_range(0, 65535)));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input t_pixel px, input bit wait_empty);
        int gap;
        gap = (tx_quiet || $urandom_range(0, 99) < 55) ? 0 : idle_span();
        if (wait_empty && gap == 0) begin
            gap = 1;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            if (wait_empty) begin
                while (sb.pending() != 0) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        sb.add_pixel(px);
    endtask

    // receiver: random stall spans
    initial begin
        int hold;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!rx_quiet && $urandom_range(0, 99) < 30) begin
                hold = idle_span();
            end
            i_stall <= (hold > 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_beat(o_result);
        end
    end

    initial begin
        t_cfg   base;
        t_cfg   c;
        t_pixel px;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_pixel    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        sb = new();
        base = sb.regs;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults
        send_pixel('{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0);
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b0);
        send_pixel('{8'haa, 8'h55, 8'h0f, 8'hf0, 1'b0}, 1'b0);
        send_pixel('{8'h01, 8'h80, 8'h7f, 8'hfe, 1'b1}, 1'b0);
        i_valid <= 1'b0;

        // every wire order, three and four bytes
        for (int fb = 0; fb < 2; fb++) begin
            for (int ord = 0; ord < 8; ord++) begin
                c = base;
                c.wire_order = 3'(ord);
                c.four_bytes = 1'(fb);
                apply_settings(c);
                send_pixel('{8'h81, 8'h42, 8'h3c, 8'hc5, 1'(ord)}, 1'b0);
                i_valid <= 1'b0;
            end
        end

        // high time above period, widest latch, dark pixel
        c = base;
        c.brightness        = 8'd0;
        c.one_high_samples  = 10'd1023;
        c.zero_high_samples = 10'd1023;
        c.bit_samples       = 10'd1;
        c.reset_samples     = 16'hffff;
        apply_settings(c);
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b0);
        i_valid <= 1'b0;

        // zero bit period, empty latch
        c = base;
        c.brightness        = 8'd1;
        c.one_high_samples  = 10'd5;
        c.zero_high_samples = 10'd0;
        c.bit_samples       = 10'd0;
        c.reset_samples     = 16'd0;
        apply_settings(c);
        send_pixel('{8'hff, 8'h80, 8'h7f, 8'h01, 1'b1}, 1'b0);
        i_valid <= 1'b0;

        c = base;
        c.wire_order        = ORD_GRBW;
        c.four_bytes        = 1'b1;
        c.brightness        = 8'd128;
        c.one_high_samples  = 10'd0;
        c.zero_high_samples = 10'd1023;
        c.bit_samples       = 10'd1023;
        apply_settings(c);
        send_pixel('{8'hff, 8'h01, 8'h80, 8'h7f, 1'b0}, 1'b0);
        i_valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            c = rand_settings();
            if (ph == 1) begin
                c.bit_samples      = 10'd1023;
                c.one_high_samples = 10'd1023;
            end
            apply_settings(c);
            tx_quiet = (ph == 0) || ($urandom_range(0, 3) == 0);
            rx_quiet = (ph == 0) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 35; k++) begin
                px = rand_pixel();
                send_pixel(px, (ph == 2 && k == 10) || $urandom_range(0, 29) == 0);
            end
            i_valid <= 1'b0;
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== led_pixel_nrz_encoder_top.f =====
rtl/core/lpne_pkg.sv
rtl/core/lpne_front.sv
rtl/core/lpne_queue.sv
rtl/core/lpne_back.sv
rtl/core/led_pixel_nrz_encoder_top.sv
rtl/core/lpne_checker.sv
bench/tb.sv
